@@ design/lfsr_bank_bit_shuffler_core_assert.svh @@
// ----------------------------------------------------------------------------
// LFSR bank bit shuffler - assertion macros
// Shared property forms for the port-level checker. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LFSR_BANK_BIT_SHUFFLER_CORE_ASSERT_SVH
`define LFSR_BANK_BIT_SHUFFLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfsr bank shuffler check failed");

// Next-cycle implication, disabled during reset
`define LBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfsr bank shuffler check failed");

`endif

@@ design/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// LFSR bank bit shuffler - package
// Payload types, mode codes, controller state and command/status structs.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // Default sizing
  localparam int NUM_LFSRS_DEF  = 32;
  localparam int STORE_BITS_DEF = 1024;

  // Fixed field widths
  localparam int LFSR_W = 5;
  localparam int LIDX_W = 5;
  localparam int SIDX_W = 10;
  localparam int ADDR_EXT_W = 16;

  // Mode codes
  localparam logic [1:0] MODE_STEP      = 2'd0;
  localparam logic [1:0] MODE_LOAD_SEED = 2'd1;
  localparam logic [1:0] MODE_LOAD_BIT  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LIDX_W-1:0] lfsr_index;
    logic [SIDX_W-1:0] slot_index;
    logic [LFSR_W-1:0] seed_value;
    logic              bit_value;
  } in_item_t;

  typedef struct packed {
    logic              out_bit;
    logic [LFSR_W-1:0] new_lfsr_value;
    logic              seed_repeat;
    logic              store_restored;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } lbs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write one zero row of the shuffle store
    logic accept;  // latch the item and read the state memories
    logic commit;  // write back and load the result register
  } lbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } lbs_status_t;

endpackage

@@ design/lfsr_bank_bit_shuffler_core.sv @@
// Flow: an input transfer in ST_IDLE latches the item and reads the state memories; in ST_EXEC
// the write-back loads the result register, once it is free, and raises out_valid.
// One item at a time: each item reads then writes the single-port state memories before the next is taken.
// A waiting result does not block the next input transfer; write-back waits for a free register.
// Reset: synchronous; LFSR valid bits clear at once, then a sweep over all STORE_BITS slots
// zeroes the shuffle store with in_ready low.
// ----------------------------------------------------------------------------
// LFSR bank bit shuffler - top level
// Bank of 5-bit Fibonacci LFSRs whose feedback bits are swapped through a
// bit store, with seed-repeat and store-restored flags.
// ----------------------------------------------------------------------------
module lfsr_bank_bit_shuffler_core import lbs_pkg::*; #(
  parameter int NUM_LFSRS  = NUM_LFSRS_DEF,
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  lbs_cmd_t    cmd;
  lbs_status_t status;

  // Sequencing
  lbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // State and step logic
  lbs_datapath #(
    .NUM_LFSRS  (NUM_LFSRS),
    .STORE_BITS (STORE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ design/lbs_datapath.sv @@
// ----------------------------------------------------------------------------
// LFSR bank bit shuffler - datapath
// LFSR value/seed memory, shuffle store memory, mismatch counter, step
// logic and result register.
// ----------------------------------------------------------------------------
module lbs_datapath import lbs_pkg::*; #(
  parameter int NUM_LFSRS  = NUM_LFSRS_DEF,
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lbs_cmd_t    cmd,
  output lbs_status_t status,
  input  in_item_t    in_data,
  output out_item_t   out_data
);

  localparam int LA_W = $clog2(NUM_LFSRS);
  localparam int SA_W = $clog2(STORE_BITS);
  localparam int CNT_W = $clog2(STORE_BITS + 1);

  // State memories: {value, seed} per LFSR, {store bit, initial bit} per slot
  logic [2*LFSR_W-1:0] lfsr_mem [NUM_LFSRS];
  logic [NUM_LFSRS-1:0] lfsr_vld_r;
  logic [1:0]          store_mem [STORE_BITS];

  in_item_t            item_r;
  logic [2*LFSR_W-1:0] lfsr_rd_r;
  logic                lfsr_rv_r;
  logic [1:0]          store_rd_r;
  logic [SA_W-1:0]     clr_cnt_r;
  logic [CNT_W-1:0]    mis_cnt_r, mis_cnt_nxt;
  out_item_t           out_r, out_nxt;

  logic [ADDR_EXT_W-1:0] in_lidx_ext, in_sidx_ext, it_lidx_ext, it_sidx_ext;
  logic [LA_W-1:0]     in_laddr, it_laddr;
  logic [SA_W-1:0]     in_saddr, it_saddr;
  logic                lfsr_ok, slot_ok;
  logic [LFSR_W-1:0]   cur_val, cur_seed, new_val;
  logic                fb, old_bit, init_bit, was_diff, now_diff;
  logic                lfsr_we, store_we;
  logic [2*LFSR_W-1:0] lfsr_wd;
  logic [1:0]          store_wd;

  // Address forms of the incoming and latched indexes
  assign in_lidx_ext = ADDR_EXT_W'(in_data.lfsr_index);
  assign in_sidx_ext = ADDR_EXT_W'(in_data.slot_index);
  assign it_lidx_ext = ADDR_EXT_W'(item_r.lfsr_index);
  assign it_sidx_ext = ADDR_EXT_W'(item_r.slot_index);
  assign in_laddr    = in_lidx_ext[LA_W-1:0];
  assign in_saddr    = in_sidx_ext[SA_W-1:0];
  assign it_laddr    = it_lidx_ext[LA_W-1:0];
  assign it_saddr    = it_sidx_ext[SA_W-1:0];
  assign lfsr_ok     = 32'(item_r.lfsr_index) < 32'(NUM_LFSRS);
  assign slot_ok     = 32'(item_r.slot_index) < 32'(STORE_BITS);

  // Never-loaded LFSRs read as zero
  assign cur_val  = lfsr_rv_r ? lfsr_rd_r[2*LFSR_W-1:LFSR_W] : '0;
  assign cur_seed = lfsr_rv_r ? lfsr_rd_r[LFSR_W-1:0] : '0;
  assign fb       = cur_val[2] ^ cur_val[0];
  assign new_val  = {fb, cur_val[LFSR_W-1:1]};
  assign old_bit  = store_rd_r[1];
  assign init_bit = store_rd_r[0];
  assign was_diff = old_bit ^ init_bit;
  assign now_diff = fb ^ init_bit;

  // Decode the latched item into writes, counter update and result
  always_comb begin
    out_nxt     = '0;
    mis_cnt_nxt = mis_cnt_r;
    lfsr_we     = 1'b0;
    store_we    = 1'b0;
    lfsr_wd     = {new_val, cur_seed};
    store_wd    = {fb, init_bit};
    case (item_r.mode)
      MODE_STEP: begin
        if (lfsr_ok && slot_ok) begin
          lfsr_we  = 1'b1;
          store_we = 1'b1;
          if (was_diff && !now_diff && (mis_cnt_r != '0)) begin
            mis_cnt_nxt = mis_cnt_r - CNT_W'(1);
          end else if (!was_diff && now_diff) begin
            mis_cnt_nxt = mis_cnt_r + CNT_W'(1);
          end
          out_nxt.out_bit        = old_bit;
          out_nxt.new_lfsr_value = new_val;
          out_nxt.seed_repeat    = (new_val == cur_seed);
          out_nxt.store_restored = (mis_cnt_nxt == '0);
        end
      end
      MODE_LOAD_SEED: begin
        if (lfsr_ok) begin
          lfsr_we = 1'b1;
          lfsr_wd = {item_r.seed_value, item_r.seed_value};
        end
      end
      MODE_LOAD_BIT: begin
        if (slot_ok) begin
          store_we = 1'b1;
          store_wd = {item_r.bit_value, item_r.bit_value};
          if (was_diff && (mis_cnt_r != '0)) begin
            mis_cnt_nxt = mis_cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Latch the item and read both memories on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r     <= in_data;
      lfsr_rd_r  <= lfsr_mem[in_laddr];
      lfsr_rv_r  <= lfsr_vld_r[in_laddr];
      store_rd_r <= store_mem[in_saddr];
    end
  end

  // LFSR memory write port
  always_ff @(posedge clk) begin
    if (cmd.commit && lfsr_we) begin
      lfsr_mem[it_laddr] <= lfsr_wd;
    end
  end

  // Valid bits: cleared by reset, set by any write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_vld_r <= '0;
    end else if (cmd.commit && lfsr_we) begin
      lfsr_vld_r[it_laddr] <= 1'b1;
    end
  end

  // Shuffle store write port, shared with the clearing sweep
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      store_mem[clr_cnt_r] <= 2'b00;
    end else if (cmd.commit && store_we) begin
      store_mem[it_saddr] <= store_wd;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + SA_W'(1);
    end
  end

  assign status.clear_last = (clr_cnt_r == SA_W'(STORE_BITS - 1));

  // Mismatch counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mis_cnt_r <= '0;
    end else if (cmd.commit) begin
      mis_cnt_r <= mis_cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

@@ design/lbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// LFSR bank bit shuffler - controller
// Sequences the clearing sweep, item transfer and write-back, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module lbs_ctrl import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  lbs_status_t status,
  output lbs_cmd_t    cmd
);

  lbs_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/lbs_checker.sv @@
// ----------------------------------------------------------------------------
// LFSR bank bit shuffler - port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "lfsr_bank_bit_shuffler_core_assert.svh"

module lbs_checker import lbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds its value
  `LBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // One item at a time: busy for the cycle after a transfer
  `LBS_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)

  // With the result register empty, out_valid rises after the write-back in ST_EXEC
  `LBS_ASSERT_IMP(a_result_latency, in_valid && in_ready && !out_valid, ##2 out_valid)

endmodule

bind lfsr_bank_bit_shuffler_core lbs_checker u_lbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
